// File: src/descending_pattern_check_runs_macros.svh
// assertion macros for the descending pattern checker
`ifndef DESCENDING_PATTERN_CHECK_RUNS_MACROS_SVH
`define DESCENDING_PATTERN_CHECK_RUNS_MACROS_SVH
`ifndef SYNTHESIS
`define DPCR_ASSERT_NOW(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("dpcr assertion failed");
`define DPCR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dpcr assertion failed");
`else
`define DPCR_ASSERT_NOW(label, expr)
`define DPCR_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// File: src/dpcr_pkg.sv
`timescale 1ns / 1ps
package dpcr_pkg;

    localparam int WORD_W     = 32;
    localparam int KIND_W     = 3;
    localparam int MODE_W     = 2;
    localparam int ITEMS_MAX  = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;
    localparam int DIST_LIMIT = 10;

    localparam logic signed [WORD_W:0] DIST_HI = (WORD_W + 1)'(DIST_LIMIT);

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_REPORT_RUNS    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INDEX_BASE     = 2'd2;

    // run modes
    localparam logic [MODE_W-1:0] MODE_OKAY   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BAD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CONST  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OFFSET = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] first;
        logic [WORD_W-1:0] last_idx;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] offset;
        logic              ok;
        logic              eoc;
    } item_t;

    typedef struct packed {
        logic [ITEMS_MAX-1:0]   mask;
        item_t [ITEMS_MAX-1:0]  items;
    } bundle_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] offset;
        logic [WORD_W-1:0] prev;
    } run_state_t;

    typedef struct packed {
        run_state_t st;
        logic       emit;
        item_t      item;
    } cls_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // classify one word against the current run, closing the run if it breaks
    function automatic cls_t classify(
        input run_state_t        st,
        input logic [WORD_W-1:0] w,
        input logic [WORD_W-1:0] idx,
        input logic [WORD_W-1:0] e,
        input logic              has_next,
        input logic [WORD_W-1:0] nxt,
        input logic              report_en,
        input logic              ok,
        input logic [WORD_W-1:0] base
    );
        cls_t                    r;
        logic                    keep;
        logic                    change;
        logic [MODE_W-1:0]       nmode;
        logic [WORD_W-1:0]       d;
        logic signed [WORD_W:0]  diff;
        logic                    near;
        r      = '0;
        keep   = 1'b0;
        change = 1'b0;
        nmode  = st.mode;
        unique case (st.mode)
            MODE_CONST:  keep = (w == st.prev);
            MODE_OKAY:   keep = (w == e);
            MODE_OFFSET: keep = (w == e + st.offset);
            default:     keep = 1'b0;
        endcase
        d    = w - e;
        diff = $signed({d[WORD_W-1], d}) - $signed({st.offset[WORD_W-1], st.offset});
        near = (diff < DIST_HI) && (diff > -DIST_HI);
        r.st = st;
        if (!keep) begin
            if (w == e) begin
                change = 1'b1;
                nmode  = MODE_OKAY;
            end else if (has_next && nxt == e - 1'b1) begin
                change = 1'b1;
                nmode  = MODE_BAD;
            end else if (has_next && w == nxt) begin
                change = 1'b1;
                nmode  = MODE_CONST;
            end else if (near) begin
                change      = 1'b1;
                nmode       = MODE_OFFSET;
                r.st.offset = d;
            end else if (st.mode != MODE_BAD) begin
                change = 1'b1;
                nmode  = MODE_BAD;
            end
        end
        // closing item describes the run as it was before this word
        r.emit          = change && report_en && (st.start != idx);
        r.item.kind     = {1'b0, st.mode};
        r.item.first    = st.start + base;
        r.item.last_idx = (idx - 1'b1) + base;
        r.item.value    = st.prev;
        r.item.offset   = (st.mode == MODE_OFFSET) ? st.offset : '0;
        r.item.ok       = ok;
        r.item.eoc      = 1'b0;
        if (change) begin
            r.st.mode  = nmode;
            r.st.start = idx;
        end
        r.st.prev = w;
        return r;
    endfunction

endpackage

// File: src/dpcr_queue.sv
`timescale 1ns / 1ps
module dpcr_queue #(
    parameter int DEPTH = dpcr_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  dpcr_pkg::bundle_t   push_data,
    input  logic                pop,
    output dpcr_pkg::bundle_t   head,
    output dpcr_pkg::q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dpcr_pkg::bundle_t slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = slots[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// File: src/dpcr_front.sv
`timescale 1ns / 1ps
module dpcr_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [31:0]         s_data_word,
    input  logic [31:0]         pattern_length,
    input  logic                report_runs,
    input  logic [31:0]         index_base,
    input  dpcr_pkg::q_status_t q_status,
    output logic                push,
    output dpcr_pkg::bundle_t   push_data
);

    dpcr_pkg::run_state_t run_reg, run_next;
    logic [31:0] word_index_reg, word_index_next;
    logic [31:0] expected_reg, expected_next;
    logic [31:0] pending_word_reg, pending_word_next;
    logic        pending_valid_reg, pending_valid_next;
    logic        mismatch_reg, mismatch_next;

    logic [31:0] len;
    logic [31:0] exp0;
    logic [31:0] exp1;
    logic [31:0] arrive_e;
    logic        mis;
    logic        report_en;
    logic        last_word;
    logic        accept;
    dpcr_pkg::cls_t       cls_a;
    dpcr_pkg::cls_t       cls_b;
    dpcr_pkg::run_state_t st1;
    dpcr_pkg::item_t      fin;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        len       = (pattern_length == '0) ? 32'd1 : pattern_length;
        exp0      = (word_index_reg == '0) ? len - 32'd1 : expected_reg;
        arrive_e  = pending_valid_reg ? exp0 - 32'd1 : exp0;
        mis       = mismatch_reg | (s_data_word != arrive_e);
        report_en = report_runs & mis;
        // the held word is classified now that its successor is here
        cls_a = dpcr_pkg::classify(run_reg, pending_word_reg, word_index_reg - 32'd1, exp0,
                                   1'b1, s_data_word, report_en, !mis, index_base);
        st1   = pending_valid_reg ? cls_a.st : run_reg;
        exp1  = pending_valid_reg ? exp0 - 32'd1 : exp0;
        last_word = (word_index_reg >= len - 32'd1);
        // last word of the block has no lookahead
        cls_b = dpcr_pkg::classify(st1, s_data_word, word_index_reg, exp1,
                                   1'b0, '0, report_en, !mis, index_base);
        fin = '0;
        fin.ok  = !mis;
        fin.eoc = 1'b1;
        if (report_en) begin
            fin.kind     = {1'b0, cls_b.st.mode};
            fin.first    = cls_b.st.start + index_base;
            fin.last_idx = word_index_reg + index_base;
            fin.value    = cls_b.st.prev;
            fin.offset   = (cls_b.st.mode == dpcr_pkg::MODE_OFFSET) ? cls_b.st.offset : '0;
        end else begin
            fin.kind = dpcr_pkg::KIND_NONE;
        end

        push_data.items[0] = cls_a.item;
        push_data.items[1] = cls_b.item;
        push_data.items[2] = fin;
        push_data.mask     = {last_word, last_word & cls_b.emit,
                              pending_valid_reg & cls_a.emit};
        push = accept && (push_data.mask != '0);

        run_next           = run_reg;
        word_index_next    = word_index_reg;
        expected_next      = expected_reg;
        pending_word_next  = pending_word_reg;
        pending_valid_next = pending_valid_reg;
        mismatch_next      = mismatch_reg;
        if (accept) begin
            if (last_word) begin
                run_next           = '0;
                word_index_next    = '0;
                expected_next      = len - 32'd1;
                pending_valid_next = 1'b0;
                mismatch_next      = 1'b0;
            end else begin
                run_next           = st1;
                word_index_next    = word_index_reg + 32'd1;
                expected_next      = exp1;
                pending_word_next  = s_data_word;
                pending_valid_next = 1'b1;
                mismatch_next      = mis;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg           <= '0;
            word_index_reg    <= '0;
            expected_reg      <= '0;
            pending_valid_reg <= 1'b0;
            mismatch_reg      <= 1'b0;
        end else begin
            run_reg           <= run_next;
            word_index_reg    <= word_index_next;
            expected_reg      <= expected_next;
            pending_valid_reg <= pending_valid_next;
            mismatch_reg      <= mismatch_next;
        end
    end

    always_ff @(posedge aclk) begin
        pending_word_reg <= pending_word_next;
    end

endmodule

// File: src/dpcr_back.sv
`timescale 1ns / 1ps
module dpcr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  dpcr_pkg::bundle_t   head,
    input  dpcr_pkg::q_status_t q_status,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output dpcr_pkg::item_t     m_item
);

    logic [dpcr_pkg::ITEMS_MAX-1:0] done_reg, done_next;
    logic [dpcr_pkg::ITEMS_MAX-1:0] rem;
    logic [dpcr_pkg::ITEMS_MAX-1:0] pick;
    logic                           load;
    logic                           m_valid_reg, m_valid_next;
    dpcr_pkg::item_t                item_reg, item_next;

    always_comb begin
        rem  = head.mask & ~done_reg;
        // lowest outstanding item keeps the model's order
        pick = rem & (~rem + 1'b1);
        load = !q_status.empty && (!m_valid_reg || m_ready) && (rem != '0);
        pop  = load && ((rem & ~pick) == '0);
        case (pick)
            3'b001:  item_next = head.items[0];
            3'b010:  item_next = head.items[1];
            default: item_next = head.items[2];
        endcase
        if (pop) begin
            done_next = '0;
        end else if (load) begin
            done_next = done_reg | pick;
        end else begin
            done_next = done_reg;
        end
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = item_reg;

endmodule

// File: src/descending_pattern_check_runs.sv
`timescale 1ns / 1ps
// Checks a read-back block of pattern_length words that should count down to 0.
// Input channel s_valid/s_ready/s_data_word takes one word per item; the result
// channel m_valid/m_ready carries run descriptors and, on the last word of each
// block, a summary item with m_end_of_check set and the final m_pattern_ok.
// Run descriptors appear only when report_runs is 1 and a word has mismatched.
// Registers over APB (pready always high): 0x0 pattern_length, 0x4 report_runs,
// 0x8 index_base; write them only while no block is in progress.
// Throughput: one word per cycle while the queue is not full. A word yields at
// most one result, except the last word of a block, which yields up to three;
// the output register sends one result per cycle while m_ready stays high.
// Each result is registered in the queue and then in the output register.
// A queue of QUEUE_DEPTH word bundles sits between classifier and output, so
// input keeps flowing while the receiver stalls until that queue fills.
// Reset clears the run state, the queue and the output; registers return to
// pattern_length 1, reporting off, index_base 0.
module descending_pattern_check_runs #(
    parameter int QUEUE_DEPTH = dpcr_pkg::QUEUE_DEPTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [31:0]                           s_data_word,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [2:0]                            m_run_kind,
    output logic [31:0]                           m_run_first,
    output logic [31:0]                           m_run_end,
    output logic [31:0]                           m_run_value,
    output logic signed [31:0]                    m_run_offset,
    output logic                                  m_pattern_ok,
    output logic                                  m_end_of_check,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dpcr_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    `include "descending_pattern_check_runs_macros.svh"

    logic [31:0] pattern_length_reg;
    logic        report_runs_reg;
    logic [31:0] index_base_reg;
    logic        cfg_wr;
    logic [dpcr_pkg::REG_IDX_W-1:0] reg_idx;

    logic                q_push;
    logic                q_pop;
    dpcr_pkg::bundle_t   q_in;
    dpcr_pkg::bundle_t   q_head;
    dpcr_pkg::q_status_t q_status;
    dpcr_pkg::item_t     out_item;

    logic                out_none;
    logic                none_zeroed;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[dpcr_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= 32'd1;
            report_runs_reg    <= 1'b0;
            index_base_reg     <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                dpcr_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= pwdata;
                dpcr_pkg::REG_REPORT_RUNS:    report_runs_reg    <= pwdata[0];
                dpcr_pkg::REG_INDEX_BASE:     index_base_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dpcr_pkg::REG_PATTERN_LENGTH: prdata = pattern_length_reg;
            dpcr_pkg::REG_REPORT_RUNS:    prdata = {31'd0, report_runs_reg};
            dpcr_pkg::REG_INDEX_BASE:     prdata = index_base_reg;
            default:                      prdata = '0;
        endcase
    end

    dpcr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_word    (s_data_word),
        .pattern_length (pattern_length_reg),
        .report_runs    (report_runs_reg),
        .index_base     (index_base_reg),
        .q_status       (q_status),
        .push           (q_push),
        .push_data      (q_in)
    );

    dpcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    dpcr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (q_head),
        .q_status (q_status),
        .pop      (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (out_item)
    );

    assign m_run_kind     = out_item.kind;
    assign m_run_first    = out_item.first;
    assign m_run_end      = out_item.last_idx;
    assign m_run_value    = out_item.value;
    assign m_run_offset   = $signed(out_item.offset);
    assign m_pattern_ok   = out_item.ok;
    assign m_end_of_check = out_item.eoc;

    assign out_none    = m_valid && (m_run_kind == dpcr_pkg::KIND_NONE);
    assign none_zeroed = m_end_of_check && (m_run_first == '0) && (m_run_offset == '0);

    // run descriptors only exist once the check has failed
    `DPCR_ASSERT_IMPL(a_run_only_on_fail, m_valid && !m_end_of_check, !m_pattern_ok)
    // the no-run kind appears only as the block summary, with zeroed fields
    `DPCR_ASSERT_IMPL(a_none_is_summary, out_none, none_zeroed)
    // the queue is never written while full
    `DPCR_ASSERT_IMPL(a_no_overflow, q_push, !q_status.full)
    // a bundle is only removed while something is queued
    `DPCR_ASSERT_IMPL(a_no_underflow, q_pop, !q_status.empty)

endmodule

// File: bench/descending_pattern_check_runs_test.sv
`timescale 1ns / 1ps
module descending_pattern_check_runs_test;

    localparam int HALF_PERIOD  = 2;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 240;

    typedef struct packed {
        logic [dpcr_pkg::KIND_W-1:0] kind;
        logic [dpcr_pkg::WORD_W-1:0] first_idx;
        logic [dpcr_pkg::WORD_W-1:0] end_idx;
        logic [dpcr_pkg::WORD_W-1:0] value;
        logic [dpcr_pkg::WORD_W-1:0] disp;
        logic                        ok;
        logic                        eoc;
    } run_rec_t;

    typedef enum {SEG_GOOD, SEG_LONE_BAD, SEG_REPEAT, SEG_SHIFTED, SEG_NOISE} seg_kind_t;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_valid     = 1'b0;
    logic                            s_ready;
    logic [31:0]                     s_data_word = '0;
    logic                            m_valid;
    logic                            m_ready     = 1'b0;
    logic [2:0]                      m_run_kind;
    logic [31:0]                     m_run_first;
    logic [31:0]                     m_run_end;
    logic [31:0]                     m_run_value;
    logic signed [31:0]              m_run_offset;
    logic                            m_pattern_ok;
    logic                            m_end_of_check;
    logic                            psel        = 1'b0;
    logic                            penable     = 1'b0;
    logic                            pwrite      = 1'b0;
    logic [dpcr_pkg::APB_ADDR_W-1:0] paddr       = '0;
    logic [31:0]                     pwdata      = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    // register shadows
    logic [31:0] len_reg    = 32'd1;
    logic        report_reg = 1'b0;
    logic [31:0] base_reg   = '0;

    // predicted checker state
    logic [dpcr_pkg::MODE_W-1:0] cur_mode;
    logic [31:0]                 cur_start;
    logic [31:0]                 word_pos;
    logic [31:0]                 want_value;
    logic [31:0]                 run_disp;
    logic [31:0]                 last_word;
    logic [31:0]                 held_word;
    logic                        held_valid;
    logic                        failed_seen;

    logic [31:0] pending_words[$];
    run_rec_t    expected_runs[$];

    int  send_idle     = 34;
    int  recv_idle     = 62;
    bit  send_hold     = 1'b0;
    int  cycle_count   = 0;
    int  words_taken   = 0;
    int  results_seen  = 0;
    int  settings_used = 0;
    int  mismatches    = 0;
    int  kind_count[8] = '{default: 0};

    descending_pattern_check_runs u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_run_kind    (m_run_kind),
        .m_run_first   (m_run_first),
        .m_run_end     (m_run_end),
        .m_run_value   (m_run_value),
        .m_run_offset  (m_run_offset),
        .m_pattern_ok  (m_pattern_ok),
        .m_end_of_check(m_end_of_check),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns  %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic clear_block();
        cur_mode    = dpcr_pkg::MODE_OKAY;
        cur_start   = '0;
        word_pos    = '0;
        want_value  = len_reg - 32'd1;
        run_disp    = '0;
        last_word   = '0;
        held_word   = '0;
        held_valid  = 1'b0;
        failed_seen = 1'b0;
    endtask

    task automatic emit_run(input logic [dpcr_pkg::KIND_W-1:0] kind,
                            input logic [31:0] first_idx,
                            input logic [31:0] end_idx, input logic [31:0] value,
                            input logic [31:0] disp, input logic eoc);
        run_rec_t r;
        r.kind      = kind;
        r.first_idx = first_idx;
        r.end_idx   = end_idx;
        r.value     = value;
        r.disp      = disp;
        r.ok        = !failed_seen;
        r.eoc       = eoc;
        expected_runs.push_back(r);
    endtask

    // the run ends just before index stop; empty runs are dropped
    task automatic close_current(input logic [31:0] stop);
        if (cur_start != stop && report_reg && failed_seen)
            emit_run({1'b0, cur_mode}, cur_start + base_reg, stop - 32'd1 + base_reg,
                     last_word, (cur_mode == dpcr_pkg::MODE_OFFSET) ? run_disp : '0, 1'b0);
    endtask

    task automatic classify_word(input logic [31:0] w, input logic [31:0] idx,
                                 input logic [31:0] e, input logic has_next,
                                 input logic [31:0] nxt);
        logic                        stay;
        logic                        change;
        logic [dpcr_pkg::MODE_W-1:0] next_mode;
        logic [31:0]                 d;
        longint                      gap;
        case (cur_mode)
            dpcr_pkg::MODE_CONST:  stay = (w == last_word);
            dpcr_pkg::MODE_OKAY:   stay = (w == e);
            dpcr_pkg::MODE_OFFSET: stay = (w == e + run_disp);
            default:               stay = 1'b0;
        endcase
        d   = w - e;
        // distance between displacements is exact, not wrapped
        gap = longint'($signed(d)) - longint'($signed(run_disp));
        if (gap < 0)
            gap = -gap;
        change    = 1'b0;
        next_mode = cur_mode;
        if (!stay) begin
            change = 1'b1;
            if (w == e)
                next_mode = dpcr_pkg::MODE_OKAY;
            else if (has_next && nxt == e - 32'd1)
                next_mode = dpcr_pkg::MODE_BAD;
            else if (has_next && w == nxt)
                next_mode = dpcr_pkg::MODE_CONST;
            else if (gap < dpcr_pkg::DIST_LIMIT)
                next_mode = dpcr_pkg::MODE_OFFSET;
            else if (cur_mode != dpcr_pkg::MODE_BAD)
                next_mode = dpcr_pkg::MODE_BAD;
            else
                change = 1'b0;
        end
        if (change) begin
            close_current(idx);
            if (next_mode == dpcr_pkg::MODE_OFFSET)
                run_disp = d;
            cur_start = idx;
            cur_mode  = next_mode;
        end
        last_word = w;
    endtask

    // one word in, classify the held word with this one as lookahead
    task automatic predict_word(input logic [31:0] w);
        logic [31:0] len;
        logic [31:0] arrive;
        len = (len_reg == '0) ? 32'd1 : len_reg;
        if (word_pos == '0)
            want_value = len - 32'd1;
        arrive = held_valid ? want_value - 32'd1 : want_value;
        if (w != arrive)
            failed_seen = 1'b1;
        if (held_valid) begin
            classify_word(held_word, word_pos - 32'd1, want_value, 1'b1, w);
            want_value = want_value - 32'd1;
        end
        if ({1'b0, word_pos} + 33'd1 >= {1'b0, len}) begin
            classify_word(w, word_pos, want_value, 1'b0, '0);
            if (report_reg && failed_seen)
                emit_run({1'b0, cur_mode}, cur_start + base_reg, word_pos + base_reg,
                         last_word, (cur_mode == dpcr_pkg::MODE_OFFSET) ? run_disp : '0,
                         1'b1);
            else
                emit_run(dpcr_pkg::KIND_NONE, '0, '0, '0, '0, 1'b1);
            clear_block();
        end else begin
            held_word  = w;
            held_valid = 1'b1;
            word_pos   = word_pos + 32'd1;
        end
    endtask

    task automatic check_result();
        run_rec_t want;
        if (expected_runs.size() == 0) begin
            report_mismatch("result with nothing outstanding, run_kind",
                            32'(m_run_kind), '0);
            return;
        end
        want = expected_runs.pop_front();
        results_seen++;
        kind_count[want.kind]++;
        if (m_run_kind !== want.kind)
            report_mismatch("run_kind", 32'(m_run_kind), 32'(want.kind));
        if (m_run_first !== want.first_idx)
            report_mismatch("run_first", m_run_first, want.first_idx);
        if (m_run_end !== want.end_idx)
            report_mismatch("run_end", m_run_end, want.end_idx);
        if (m_run_value !== want.value)
            report_mismatch("run_value", m_run_value, want.value);
        if (m_run_offset !== want.disp)
            report_mismatch("run_offset", m_run_offset, want.disp);
        if (m_pattern_ok !== want.ok)
            report_mismatch("pattern_ok", 32'(m_pattern_ok), 32'(want.ok));
        if (m_end_of_check !== want.eoc)
            report_mismatch("end_of_check", 32'(m_end_of_check), 32'(want.eoc));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_word(s_data_word);
                words_taken++;
            end
            if (!s_valid || s_ready) begin
                if (!send_hold && pending_words.size() != 0 &&
                        $urandom_range(99) >= send_idle) begin
                    s_valid     <= 1'b1;
                    s_data_word <= pending_words.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
            if (m_valid && m_ready)
                check_result();
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("descending_pattern_check_runs: mismatch");
            $finish;
        end
    end

    task automatic reg_write(input logic [dpcr_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            dpcr_pkg::REG_PATTERN_LENGTH: len_reg    = val;
            dpcr_pkg::REG_REPORT_RUNS:    report_reg = val[0];
            dpcr_pkg::REG_INDEX_BASE:     base_reg   = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] len, input logic report,
                             input logic [31:0] base);
        reg_write(dpcr_pkg::REG_PATTERN_LENGTH, len);
        reg_write(dpcr_pkg::REG_REPORT_RUNS, {31'd0, report});
        reg_write(dpcr_pkg::REG_INDEX_BASE, base);
        settings_used++;
        @(negedge aclk);
    endtask

    // wait until every word is taken and every result is back, then let it settle
    task automatic drain();
        @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_runs.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic queue_block(input logic [31:0] len, input bit corrupt);
        logic [31:0] e;
        logic [31:0] w;
        logic [31:0] seg_disp;
        logic [31:0] seg_val;
        seg_kind_t   seg_kind;
        int          seg_left;
        seg_kind = SEG_GOOD;
        seg_left = 0;
        seg_disp = '0;
        seg_val  = '0;
        for (int unsigned i = 0; i < len; i++) begin
            e = len - 32'd1 - i;
            if (seg_left == 0) begin
                seg_kind = corrupt ? seg_kind_t'($urandom_range(4)) : SEG_GOOD;
                seg_left = $urandom_range(5, 1);
                seg_val  = $urandom_range(1) ? e : $urandom();
                seg_disp = $urandom_range(1) ? $urandom_range(40) - 20 : $urandom();
            end
            case (seg_kind)
                SEG_LONE_BAD: begin
                    w        = $urandom();
                    seg_left = 1;
                end
                SEG_REPEAT: w = seg_val;
                SEG_SHIFTED: begin
                    // let the displacement wander, sometimes past the near limit
                    if ($urandom_range(3) == 0)
                        seg_disp = seg_disp + $urandom_range(24) - 12;
                    w = e + seg_disp;
                end
                SEG_NOISE: w = $urandom_range(1) ? $urandom() : e ^ (32'd1 << $urandom_range(31));
                default: w = e;
            endcase
            pending_words.push_back(w);
            seg_left--;
        end
    endtask

    initial begin
        logic [31:0] len;
        logic [31:0] base;
        logic        report;
        int          phase_words;
        int          blocks;
        bit          paused;
        paused = 1'b0;
        clear_block();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: one-word blocks, reporting off
        pending_words.push_back(32'd0);
        pending_words.push_back(32'hFFFF_FFFF);
        drain();

        // zero length behaves as one word
        configure(32'd0, 1'b1, 32'd0);
        pending_words.push_back(32'd0);
        pending_words.push_back(32'd5);
        drain();

        // lone bad word, then a constant tail, indices wrapping past the signed limit
        configure(32'd6, 1'b1, 32'h7FFF_FFFE);
        pending_words.push_back(32'd5);
        pending_words.push_back(32'd77);
        pending_words.push_back(32'd3);
        pending_words.push_back(32'd2);
        pending_words.push_back(32'd2);
        pending_words.push_back(32'd2);
        drain();

        // offset run broken by a bad word, back to okay, then an all-ones bad word
        configure(32'd8, 1'b1, 32'hFFFF_FFFF);
        pending_words.push_back(32'd10);
        pending_words.push_back(32'd9);
        pending_words.push_back(32'd8);
        pending_words.push_back(32'd11);
        pending_words.push_back(32'd3);
        pending_words.push_back(32'd2);
        pending_words.push_back(32'hFFFF_FFFF);
        pending_words.push_back(32'd0);
        drain();

        // longest block, cut short by shrinking the length part way through
        configure(32'hFFFF_FFFF, 1'b1, 32'h8000_0000);
        pending_words.push_back(32'hFFFF_FFFE);
        pending_words.push_back(32'hFFFF_FFFD);
        pending_words.push_back(32'd0);
        drain();
        reg_write(dpcr_pkg::REG_PATTERN_LENGTH, 32'd4);
        @(negedge aclk);
        pending_words.push_back(32'hFFFF_FFFC);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle   = (ph == 0) ? 34 : (ph == 1) ? 62 : 0;
            recv_idle   = (ph == 0) ? 62 : (ph == 1) ? 34 : 0;
            phase_words = 0;
            while (phase_words < RANDOM_WORDS / 3) begin
                case ($urandom_range(9))
                    0:       len = 32'd0;
                    1:       len = 32'd1;
                    2:       len = $urandom_range(40, 20);
                    default: len = $urandom_range(14, 2);
                endcase
                case ($urandom_range(3))
                    0:       base = 32'd0;
                    1:       base = 32'h7FFF_FFFC;
                    2:       base = 32'hFFFF_FFFE;
                    default: base = $urandom();
                endcase
                report = ($urandom_range(4) != 0);
                configure(len, report, base);
                if (len == '0)
                    len = 32'd1;
                blocks = $urandom_range(5, 2);
                for (int b = 0; b < blocks && phase_words < RANDOM_WORDS / 3; b++) begin
                    queue_block(len, $urandom_range(3) != 0);
                    phase_words += int'(len);
                end
                if (ph == 2 && !paused) begin
                    // hold the sender until the output side has caught up
                    repeat (3) @(negedge aclk);
                    send_hold = 1'b1;
                    while (s_valid || expected_runs.size() != 0)
                        @(negedge aclk);
                    send_hold = 1'b0;
                    paused    = 1'b1;
                end
                drain();
            end
        end

        repeat (20) @(negedge aclk);
        if (expected_runs.size() != 0)
            report_mismatch("results never delivered", 32'(expected_runs.size()), '0);
        $display("%0d words checked as %0d results over %0d register settings",
                 words_taken, results_seen, settings_used);
        $display("run kinds seen: okay %0d, bad %0d, constant %0d, offset %0d, none %0d",
                 kind_count[dpcr_pkg::MODE_OKAY], kind_count[dpcr_pkg::MODE_BAD],
                 kind_count[dpcr_pkg::MODE_CONST], kind_count[dpcr_pkg::MODE_OFFSET],
                 kind_count[dpcr_pkg::KIND_NONE]);
        if (mismatches == 0)
            $display("descending_pattern_check_runs: match");
        else
            $display("descending_pattern_check_runs: mismatch");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/dpcr_pkg.sv
src/dpcr_queue.sv
src/dpcr_front.sv
src/dpcr_back.sv
src/descending_pattern_check_runs.sv
bench/descending_pattern_check_runs_test.sv
